### hdl/stps_pkg.sv
`default_nettype none

package stps_pkg;

  // Fixed field widths of the ports
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned IN_KEY_W = 32;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned POS_W    = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

  // Position reported when the key lies below the entry checked last
  localparam logic [POS_W-1:0] POS_NONE = '1;

  // Status from the search sequencer to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } stps_status_t;

endpackage

`default_nettype wire

### hdl/stps_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module stps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/stps_ctrl.sv
`default_nettype none

// Binary search sequencer: one table read and one key compare per step
module stps_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  search_go,
  input  wire logic signed [KEY_WIDTH-1:0]           search_key,
  input  wire logic [((($clog2(TABLE_DEPTH+1)) > stps_pkg::CNT_W) ?
                      ($clog2(TABLE_DEPTH+1)) : stps_pkg::CNT_W)-1:0] entry_count,
  output logic                                       rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]             rd_addr,
  input  wire logic [KEY_WIDTH-1:0]                  rd_data,
  output stps_pkg::stps_status_t                     status,
  output logic [stps_pkg::POS_W-1:0]                 found_position
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW  = (CW > stps_pkg::CNT_W) ? CW : stps_pkg::CNT_W;
  localparam int unsigned PXW = (CW > stps_pkg::POS_W) ? CW : stps_pkg::POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               top_r, top_nxt;
  logic [CW-1:0]               bottom_r, bottom_nxt;
  logic [AW-1:0]               mid_r, mid_nxt;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;

  logic [CW-1:0]               n_clamp;
  logic [CW-1:0]               n_half;
  logic [CW-1:0]               mid_ext;
  logic signed [KEY_WIDTH-1:0] entry;
  logic                        key_gt, key_eq, key_lt;
  logic [CW-1:0]               nt, nb;
  logic [CW:0]                 bound_sum;
  logic [CW-1:0]               nmid;
  logic                        cont;
  logic [PXW-1:0]              mid_pos, bottom_pos;

  // Count of zero searches entry 0 only; large counts saturate to the depth
  always_comb begin
    if (entry_count == '0) begin
      n_clamp = CW'(1);
    end else if (entry_count > NW'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = entry_count[CW-1:0];
    end
  end

  // First probe: half the clamped count, always below the depth
  assign n_half = n_clamp >> 1;

  // Shared compare of the key against the entry just read
  assign entry   = $signed(rd_data);
  assign key_gt  = key_r > entry;
  assign key_eq  = key_r == entry;
  assign key_lt  = key_r < entry;
  assign mid_ext = CW'(mid_r);

  // Narrowed bounds and the next probe
  always_comb begin
    if (key_gt) begin
      nt = top_r;
      nb = mid_ext;
    end else begin
      nt = mid_ext;
      nb = bottom_r;
    end
  end
  assign bound_sum = {1'b0, nt} + {1'b0, nb};
  assign nmid      = bound_sum[CW:1];
  assign cont      = nt > (nb + CW'(1));

  assign mid_pos    = PXW'(mid_r);
  assign bottom_pos = PXW'(bottom_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    bottom_nxt     = bottom_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    rd_en          = 1'b0;
    rd_addr        = mid_r;
    status.busy    = state_r != S_IDLE;
    status.done    = 1'b0;
    found_position = mid_pos[stps_pkg::POS_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (search_go) begin
          key_nxt    = search_key;
          top_nxt    = n_clamp;
          bottom_nxt = '0;
          rd_en      = 1'b1;
          if (n_clamp > CW'(1)) begin
            mid_nxt   = n_half[AW-1:0];
            rd_addr   = n_half[AW-1:0];
            state_nxt = S_CMP;
          end else begin
            rd_addr   = '0;
            state_nxt = S_FIN;
          end
        end
      end
      S_CMP: begin
        if (key_eq) begin
          status.done = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          top_nxt    = nt;
          bottom_nxt = nb;
          rd_en      = 1'b1;
          if (cont) begin
            mid_nxt   = nmid[AW-1:0];
            rd_addr   = nmid[AW-1:0];
            state_nxt = S_CMP;
          end else begin
            rd_addr   = nb[AW-1:0];
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        status.done = 1'b1;
        if (key_lt) begin
          found_position = stps_pkg::POS_NONE;
        end else begin
          found_position = bottom_pos[stps_pkg::POS_W-1:0];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    mid_r    <= mid_nxt;
    key_r    <= key_nxt;
  end

endmodule

`default_nettype wire

### hdl/sorted_table_preceding_search.sv
`default_nettype none

// Channel  Direction  Transfer when           Payload
// in       in         start & !busy          in_command, in_entry_index, in_key_value
// out      out        out_valid (one cycle)  out_found_position
// cfg      in         cfg_valid & cfg_ready  cfg_entry_count
//
// A write command gives no result; busy stays low.
// A search reads the first probe in the accepting cycle, then one probe per
// halving step and a final check, ending early on an exact hit; the steps
// run one after another, set by the one read port and one comparator.
// The result strobes the cycle after the search ends; no receiver stall.
// Reset clears the sequencer and sets the count to the depth; table undefined.
module sorted_table_preceding_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [stps_pkg::CMD_W-1:0]           in_command,
  input  wire logic [stps_pkg::IDX_W-1:0]           in_entry_index,
  input  wire logic signed [stps_pkg::IN_KEY_W-1:0] in_key_value,
  output logic                                      out_valid,
  output logic signed [stps_pkg::POS_W-1:0]         out_found_position,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [stps_pkg::CNT_W-1:0]           cfg_entry_count
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = (CW > stps_pkg::CNT_W) ? CW : stps_pkg::CNT_W;
  localparam int unsigned IW = (CW > stps_pkg::IDX_W) ? CW : stps_pkg::IDX_W;
  localparam int unsigned XW = (KEY_WIDTH > stps_pkg::IN_KEY_W) ?
                               KEY_WIDTH : stps_pkg::IN_KEY_W;

  logic [NW-1:0]                    count_r;
  logic                             out_valid_r;
  logic [stps_pkg::POS_W-1:0]       out_pos_r;

  logic                             take;
  logic                             search_go;
  logic                             wr_en;
  logic [IW-1:0]                    idx_ext;
  logic signed [XW-1:0]             key_ext;
  logic signed [KEY_WIDTH-1:0]      key;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;
  logic [KEY_WIDTH-1:0]             rd_data;
  stps_pkg::stps_status_t           status;
  logic [stps_pkg::POS_W-1:0]       found_position;

  // Input transfer decode
  assign busy      = status.busy;
  assign take      = start && !status.busy;
  assign search_go = take && (in_command == stps_pkg::CMD_SEARCH);
  assign idx_ext   = IW'(in_entry_index);
  assign wr_en     = take && (in_command == stps_pkg::CMD_WRITE) &&
                     (idx_ext < IW'(TABLE_DEPTH));

  // Key sign-extended or trimmed to the table width
  assign key_ext = XW'(in_key_value);
  assign key     = key_ext[KEY_WIDTH-1:0];

  // Entry count register
  assign cfg_ready = !status.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= NW'(TABLE_DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      count_r <= NW'(cfg_entry_count);
    end
  end

  stps_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stps_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .search_go      (search_go),
    .search_key     (key),
    .entry_count    (count_r),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .status         (status),
    .found_position (found_position)
  );

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= status.done;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      out_pos_r <= found_position;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found_position = $signed(out_pos_r);

endmodule

`default_nettype wire
